// File: rtl/core/wsfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wsfr_pkg;

    // Width of the frame payload length counter
    localparam int LEN_BITS = 64;

    localparam logic [6:0] CTRL_LIMIT_RESET = 7'd125;

    // 7-bit length codes that announce an extended length
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    // Extended header byte counts
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] MASK_BYTES  = 4'd4;

    // Register word index on the APB port
    localparam logic REG_CTRL_LIMIT = 1'b0;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    typedef enum logic [2:0] {
        ST_HEADER    = 3'd0,
        ST_PAYLOAD   = 3'd1,
        ST_BAD_CONT  = 3'd2,
        ST_BAD_OP    = 3'd3,
        ST_CTRL_LONG = 3'd4,
        ST_CLOSE     = 3'd5,
        ST_CLOSED    = 3'd6
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [7:0]  data;
        logic [3:0]  opcode;
        logic        fin;
        logic        eof;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/core/wsfr_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module wsfr_parse
    import wsfr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_in_stall,
    input  wire logic        i_out_ready,
    input  wire logic [6:0]  i_ctrl_limit,
    output logic             o_push,
    output t_result          o_result
);

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    // input register
    logic                r_in_valid;
    logic [7:0]          r_in_byte;

    // frame state
    t_phase              r_phase, n_phase;
    logic [3:0]          r_ext, n_ext;
    logic [3:0]          r_op, n_op;
    logic                r_fin, n_fin;
    logic                r_masked, n_masked;
    logic [LEN_BITS-1:0] r_rem, n_rem;
    logic [31:0]         r_key, n_key;
    logic [1:0]          r_mpos, n_mpos;
    logic                r_frag, n_frag;
    logic [6:0]          r_cnt, n_cnt;
    logic                r_closed, n_closed;

    logic                adv;
    logic [LEN_BITS-1:0] ext_next;
    logic [LEN_BITS-1:0] fin_len;
    logic [7:0]          key_byte;
    logic                is_ctrl;

    // header finish outcome
    t_status             f_status;
    logic                f_frag;
    logic                f_closed;
    logic                f_eof;
    t_phase              f_phase;

    t_status             st;
    logic [7:0]          dat;
    logic                eof;

    assign adv        = r_in_valid & i_out_ready;
    assign o_in_stall = r_in_valid & ~i_out_ready;
    assign is_ctrl    = r_op[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall) begin
            r_in_byte <= i_in_byte;
        end
    end

    // extended length shift-in; saturates once the top byte is occupied
    always_comb begin
        if (r_rem[LEN_BITS-1 -: 8] != 8'd0) begin
            ext_next = '1;
        end else begin
            ext_next = {r_rem[LEN_BITS-9:0], r_in_byte};
        end
    end

    always_comb begin
        case (r_phase)
            PH_SECOND: fin_len = LEN_BITS'(r_in_byte[6:0]);
            PH_EXTLEN: fin_len = ext_next;
            default:   fin_len = r_rem;
        endcase
    end

    always_comb begin
        case (r_mpos)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            2'd3:    key_byte = r_key[7:0];
            default: key_byte = r_key[7:0];
        endcase
    end

    // end of header: opcode check, fragment tracking, and end of frame or close for an empty payload
    always_comb begin
        f_status = ST_HEADER;
        f_frag   = r_frag;
        f_closed = 1'b0;
        f_eof    = 1'b0;
        f_phase  = PH_PAYLOAD;
        if (r_op == OP_CONT && !r_frag) begin
            f_status = ST_BAD_CONT;
            f_closed = 1'b1;
            f_phase  = r_phase;
        end else if (!(r_op inside {OP_CONT, OP_TEXT, OP_BINARY,
                                    OP_CLOSE, OP_PING, OP_PONG})) begin
            f_status = ST_BAD_OP;
            f_closed = 1'b1;
            f_phase  = r_phase;
        end else begin
            if (r_op == OP_CONT && r_fin) begin
                f_frag = 1'b0;
            end else if (r_op == OP_TEXT || r_op == OP_BINARY) begin
                f_frag = ~r_fin;
            end
            if (fin_len == '0) begin
                f_eof   = 1'b1;
                f_phase = PH_FIRST;
                if (r_op == OP_CLOSE) begin
                    f_status = ST_CLOSE;
                    f_closed = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_ext    = r_ext;
        n_op     = r_op;
        n_fin    = r_fin;
        n_masked = r_masked;
        n_rem    = r_rem;
        n_key    = r_key;
        n_mpos   = r_mpos;
        n_frag   = r_frag;
        n_cnt    = r_cnt;
        n_closed = r_closed;
        st       = ST_HEADER;
        dat      = 8'd0;
        eof      = 1'b0;
        if (r_closed) begin
            st = ST_CLOSED;
        end else begin
            case (r_phase)
                PH_FIRST: begin
                    n_fin    = r_in_byte[7];
                    n_op     = r_in_byte[3:0];
                    n_masked = 1'b0;
                    n_rem    = '0;
                    n_key    = 32'd0;
                    n_mpos   = 2'd0;
                    n_cnt    = 7'd0;
                    n_ext    = 4'd0;
                    n_phase  = PH_SECOND;
                end
                PH_SECOND: begin
                    n_masked = r_in_byte[7];
                    if (r_in_byte[6:0] == LEN_CODE_EXT16) begin
                        n_ext   = EXT16_BYTES;
                        n_phase = PH_EXTLEN;
                    end else if (r_in_byte[6:0] == LEN_CODE_EXT64) begin
                        n_ext   = EXT64_BYTES;
                        n_phase = PH_EXTLEN;
                    end else begin
                        n_rem = fin_len;
                        if (r_in_byte[7]) begin
                            n_ext   = MASK_BYTES;
                            n_phase = PH_MASK;
                        end else begin
                            st       = f_status;
                            eof      = f_eof;
                            n_frag   = f_frag;
                            n_closed = f_closed;
                            n_phase  = f_phase;
                        end
                    end
                end
                PH_EXTLEN: begin
                    n_rem = ext_next;
                    n_ext = r_ext - 4'd1;
                    if (r_ext == 4'd1) begin
                        if (r_masked) begin
                            n_ext   = MASK_BYTES;
                            n_phase = PH_MASK;
                        end else begin
                            st       = f_status;
                            eof      = f_eof;
                            n_frag   = f_frag;
                            n_closed = f_closed;
                            n_phase  = f_phase;
                        end
                    end
                end
                PH_MASK: begin
                    n_key = {r_key[23:0], r_in_byte};
                    n_ext = r_ext - 4'd1;
                    if (r_ext == 4'd1) begin
                        st       = f_status;
                        eof      = f_eof;
                        n_frag   = f_frag;
                        n_closed = f_closed;
                        n_phase  = f_phase;
                    end
                end
                PH_PAYLOAD: begin
                    if (is_ctrl && r_cnt >= i_ctrl_limit) begin
                        st       = ST_CTRL_LONG;
                        n_closed = 1'b1;
                    end else begin
                        if (is_ctrl) begin
                            n_cnt = r_cnt + 7'd1;
                        end
                        if (r_masked) begin
                            dat    = r_in_byte ^ key_byte;
                            n_mpos = r_mpos + 2'd1;
                        end else begin
                            dat = r_in_byte;
                        end
                        st    = ST_PAYLOAD;
                        n_rem = r_rem - LEN_BITS'(1);
                        // one byte left means this is the last payload byte
                        if (r_rem == LEN_BITS'(1)) begin
                            eof     = 1'b1;
                            n_phase = PH_FIRST;
                            if (r_op == OP_CLOSE) begin
                                st       = ST_CLOSE;
                                n_closed = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    n_phase = PH_FIRST;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FIRST;
            r_ext    <= 4'd0;
            r_op     <= 4'd0;
            r_fin    <= 1'b0;
            r_masked <= 1'b0;
            r_rem    <= '0;
            r_key    <= 32'd0;
            r_mpos   <= 2'd0;
            r_frag   <= 1'b0;
            r_cnt    <= 7'd0;
            r_closed <= 1'b0;
        end else if (adv) begin
            r_phase  <= n_phase;
            r_ext    <= n_ext;
            r_op     <= n_op;
            r_fin    <= n_fin;
            r_masked <= n_masked;
            r_rem    <= n_rem;
            r_key    <= n_key;
            r_mpos   <= n_mpos;
            r_frag   <= n_frag;
            r_cnt    <= n_cnt;
            r_closed <= n_closed;
        end
    end

    assign o_push          = adv;
    assign o_result.status = st;
    assign o_result.data   = dat;
    assign o_result.opcode = n_op;
    assign o_result.fin    = n_fin;
    assign o_result.eof    = eof;

endmodule

`default_nettype wire

// File: rtl/core/wsfr_out_skid.sv
`timescale 1ns / 1ps
`default_nettype none

module wsfr_out_skid
    import wsfr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_result,
    output logic         o_ready,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_result      o_result
);

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    logic    pop;

    assign pop     = r_out_valid & ~i_stall;
    assign o_ready = ~r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else if (i_push) begin
                r_out <= i_result;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid) begin
                r_out       <= i_result;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= i_result;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

// File: rtl/core/websocket_frame_receiver.sv
// A byte accepted at the input passes the input register, then the result
// register, or the skid slot when the output side is stalling.
// Throughput: one byte per cycle; o_in_stall rises only when the result skid
// stage is full because the output side is stalling.
// Reset: i_rst_n is synchronous, active low; clears parse state, link state,
// beat valids, and sets control_payload_limit to 125.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_receiver
    import wsfr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_in_byte,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_status,
    output logic [7:0]       o_data_byte,
    output logic [3:0]       o_frame_opcode,
    output logic             o_frame_final,
    output logic             o_end_of_frame,
    // APB register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [6:0] r_ctrl_limit;
    logic       cfg_wr;
    logic       skid_ready;
    logic       push;
    t_result    result;
    t_result    out_result;

    // --- register port ---
    // Single register at word 0; paddr[2] picks the word, low bits are byte lanes.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_CTRL_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_limit <= CTRL_LIMIT_RESET;
        end else if (cfg_wr) begin
            r_ctrl_limit <= pwdata[6:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_CTRL_LIMIT) begin
            prdata = 32'(r_ctrl_limit);
        end else begin
            prdata = 32'd0;
        end
    end

    // --- frame parser: input register plus registered state update ---
    wsfr_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_byte    (i_in_byte),
        .o_in_stall   (o_in_stall),
        .i_out_ready  (skid_ready),
        .i_ctrl_limit (r_ctrl_limit),
        .o_push       (push),
        .o_result     (result)
    );

    // --- result register with skid slot that takes one more result under stall ---
    wsfr_out_skid u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (result),
        .o_ready  (skid_ready),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_result)
    );

    assign o_status       = out_result.status;
    assign o_data_byte    = out_result.data;
    assign o_frame_opcode = out_result.opcode;
    assign o_frame_final  = out_result.fin;
    assign o_end_of_frame = out_result.eof;

endmodule

`default_nettype wire

// File: rtl/core/wsfr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module wsfr_checker
    import wsfr_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [2:0] o_status,
    input wire logic [7:0] o_data_byte,
    input wire logic       o_end_of_frame
);

    logic r_link_down;
    logic out_take;

    assign out_take = o_out_valid & ~i_out_stall;

    // set once a beat reports an error, a finished close, or closed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_down <= 1'b0;
        end else if (out_take && o_status != ST_HEADER && o_status != ST_PAYLOAD) begin
            r_link_down <= 1'b1;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_data_byte) && $stable(o_end_of_frame))
        else $error("result beat changed while stalled");

    a_closed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && r_link_down |-> o_status == ST_CLOSED)
        else $error("beat after link closed is not closed");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_BAD_CONT || o_status == ST_BAD_OP
            || o_status == ST_CTRL_LONG || o_status == ST_CLOSED)
        |-> o_data_byte == 8'd0 && !o_end_of_frame)
        else $error("error beat carries data or end of frame");

    a_header_nodata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_HEADER |-> o_data_byte == 8'd0)
        else $error("header beat carries data");

endmodule

bind websocket_frame_receiver wsfr_checker u_wsfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_data_byte    (o_data_byte),
    .o_end_of_frame (o_end_of_frame)
);

`default_nettype wire
